// ----- hw/rtl/dsc_pkg.sv -----
// Package: shared types and constants for the two-sensor direction counter.
`timescale 1ns / 1ps
`default_nettype none
package dsc_pkg;

  localparam int unsigned CountWidth = 16;
  localparam int unsigned TimeWidth  = 32;
  localparam int unsigned DurWidth   = 16;

  localparam logic [DurWidth-1:0] MaxDurationReset = 16'd2000;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ENTRY = 2'd1,
    PH_EXIT  = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    EV_NONE          = 3'd0,
    EV_ENTRY_ARMED   = 3'd1,
    EV_EXIT_ARMED    = 3'd2,
    EV_ENTRY_COUNTED = 3'd3,
    EV_EXIT_COUNTED  = 3'd4,
    EV_LATE          = 3'd5,
    EV_TIMEOUT       = 3'd6
  } event_e;

  typedef struct packed {
    logic                 entry_sensor_level;
    logic                 exit_sensor_level;
    logic [TimeWidth-1:0] time_ms;
  } sample_t;

  typedef struct packed {
    logic [CountWidth-1:0] entries_count;
    logic [CountWidth-1:0] exits_count;
    logic [2:0]            event_res;
    logic [1:0]            armed_side;
  } result_t;

endpackage
`default_nettype wire

// ----- hw/rtl/dsc_step.sv -----
// Direction tracking state and the per-sample step logic.
`timescale 1ns / 1ps
`default_nettype none
module dsc_step (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              step_i,
  input  wire dsc_pkg::sample_t                  sample_i,
  input  wire logic [dsc_pkg::DurWidth-1:0]      max_dur_i,
  output dsc_pkg::result_t                       result_o
);

  dsc_pkg::phase_e                      phase_q, phase_d;
  logic [dsc_pkg::TimeWidth-1:0]        arm_time_q, arm_time_d;
  logic                                 prev_ent_q, prev_ext_q;
  logic [dsc_pkg::CountWidth-1:0]       entry_total_q, entry_total_d;
  logic [dsc_pkg::CountWidth-1:0]       exit_total_q, exit_total_d;
  dsc_pkg::event_e                      ev;

  logic                                 ent_rise, ext_rise, in_window;
  logic [dsc_pkg::TimeWidth-1:0]        gap;

  assign ent_rise  = sample_i.entry_sensor_level & ~prev_ent_q;
  assign ext_rise  = sample_i.exit_sensor_level & ~prev_ext_q;
  assign gap       = sample_i.time_ms - arm_time_q;
  assign in_window = gap <= {{(dsc_pkg::TimeWidth-dsc_pkg::DurWidth){1'b0}}, max_dur_i};

  always_comb begin
    phase_d       = phase_q;
    arm_time_d    = arm_time_q;
    entry_total_d = entry_total_q;
    exit_total_d  = exit_total_q;
    ev            = dsc_pkg::EV_NONE;
    unique case (phase_q)
      dsc_pkg::PH_ENTRY: begin
        if (ext_rise) begin
          phase_d = dsc_pkg::PH_IDLE;
          if (in_window) begin
            entry_total_d = entry_total_q + 1'b1;
            ev            = dsc_pkg::EV_ENTRY_COUNTED;
          end else begin
            ev = dsc_pkg::EV_LATE;
          end
        end else if (!in_window) begin
          phase_d = dsc_pkg::PH_IDLE;
          ev      = dsc_pkg::EV_TIMEOUT;
        end
      end
      dsc_pkg::PH_EXIT: begin
        if (ent_rise) begin
          phase_d = dsc_pkg::PH_IDLE;
          if (in_window) begin
            exit_total_d = exit_total_q + 1'b1;
            ev           = dsc_pkg::EV_EXIT_COUNTED;
          end else begin
            ev = dsc_pkg::EV_LATE;
          end
        end else if (!in_window) begin
          phase_d = dsc_pkg::PH_IDLE;
          ev      = dsc_pkg::EV_TIMEOUT;
        end
      end
      default: begin
        phase_d = dsc_pkg::PH_IDLE;
        if (ent_rise) begin
          phase_d    = dsc_pkg::PH_ENTRY;
          arm_time_d = sample_i.time_ms;
          ev         = dsc_pkg::EV_ENTRY_ARMED;
        end else if (ext_rise) begin
          phase_d    = dsc_pkg::PH_EXIT;
          arm_time_d = sample_i.time_ms;
          ev         = dsc_pkg::EV_EXIT_ARMED;
        end
      end
    endcase
  end

  always_comb begin
    result_o.entries_count = entry_total_d;
    result_o.exits_count   = exit_total_d;
    result_o.event_res     = ev;
    result_o.armed_side    = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= dsc_pkg::PH_IDLE;
      arm_time_q    <= '0;
      prev_ent_q    <= 1'b0;
      prev_ext_q    <= 1'b0;
      entry_total_q <= '0;
      exit_total_q  <= '0;
    end else if (step_i) begin
      phase_q       <= phase_d;
      arm_time_q    <= arm_time_d;
      prev_ent_q    <= sample_i.entry_sensor_level;
      prev_ext_q    <= sample_i.exit_sensor_level;
      entry_total_q <= entry_total_d;
      exit_total_q  <= exit_total_d;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/dsc_out_reg.sv -----
// Result register with valid/ready handshake toward the consumer.
`timescale 1ns / 1ps
`default_nettype none
module dsc_out_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire dsc_pkg::result_t data_i,
  output logic                  free_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output dsc_pkg::result_t      out_data_o
);

  logic             valid_q, valid_d;
  dsc_pkg::result_t data_q;

  assign free_o      = ~valid_q | out_ready_i;
  assign valid_d     = load_i | (valid_q & ~out_ready_i);
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/two_sensor_direction_counter.sv -----
// Top level of the two-sensor direction counter.
// Each transfer on the input channel is one sample of both sensor levels and a
// millisecond timestamp; it yields exactly one result holding both counters, the
// event of that sample and the armed side after it. A sample is accepted every
// cycle while the result register is empty or being drained; its result is
// registered and appears in the next cycle. Throughput is 1 sample per clock, set
// by the single result register. max_duration_ms (reset 2000) is written through
// the cfg channel, which is always ready; write it only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module two_sensor_direction_counter (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire dsc_pkg::sample_t              in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output dsc_pkg::result_t                   out_data_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [dsc_pkg::DurWidth-1:0]  cfg_data_i
);

  logic [dsc_pkg::DurWidth-1:0] max_dur_q;
  logic                         step;
  logic                         free;
  dsc_pkg::result_t             result;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = free;
  assign step        = in_valid_i & free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dur_q <= dsc_pkg::MaxDurationReset;
    end else if (cfg_valid_i) begin
      max_dur_q <= cfg_data_i;
    end
  end

  dsc_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .sample_i  (in_data_i),
    .max_dur_i (max_dur_q),
    .result_o  (result)
  );

  dsc_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .data_i      (result),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/dsc_checker.sv -----
// Port-level checker for the two-sensor direction counter, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module dsc_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_ready_o,
  input wire logic             out_valid_o,
  input wire logic             out_ready_i,
  input wire dsc_pkg::result_t out_data_o
);

  // every accepted sample leaves a result
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted sample produced no result");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // empty result register never back-pressures
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  // counted, late or timeout events always return to idle
  a_close_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.event_res == dsc_pkg::EV_ENTRY_COUNTED ||
                    out_data_o.event_res == dsc_pkg::EV_EXIT_COUNTED ||
                    out_data_o.event_res == dsc_pkg::EV_LATE ||
                    out_data_o.event_res == dsc_pkg::EV_TIMEOUT)
    |-> out_data_o.armed_side == dsc_pkg::PH_IDLE)
    else $error("closing event left a side armed");

  // entry arm events report the entry side
  a_arm_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.event_res == dsc_pkg::EV_ENTRY_ARMED
    |-> out_data_o.armed_side == dsc_pkg::PH_ENTRY)
    else $error("entry arm without entry side");

endmodule

bind two_sensor_direction_counter dsc_checker u_dsc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
